@@ rtl/point_in_polygon_test_macros.svh @@
// assertion macros for the point-in-polygon test block
// used by the port checker; no other dependencies
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PIP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pip_pkg.sv @@
// shared constants and types for the point-in-polygon test block
// no dependencies
`timescale 1ns / 1ps

package pip_pkg;

    localparam int unsigned COORD_BITS_DEF  = 16;
    localparam int unsigned MIN_VERTICES    = 3;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned OUT_DATA_W      = 8;

    // per-vertex flags that travel with the edge jobs
    typedef struct packed {
        logic last;
        logic enough;
    } t_item_ctl;

    localparam int unsigned CTL_W = $bits(t_item_ctl);

endpackage

@@ rtl/pip_front.sv @@
// front end: takes vertices, keeps polygon state, turns each vertex into edge jobs
// depends on pip_pkg
`timescale 1ns / 1ps

module pip_front #(
    parameter int unsigned COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_BITS-1:0]  i_query_x,
    input  logic signed [COORD_BITS-1:0]  i_query_y,
    input  logic signed [COORD_BITS-1:0]  i_vertex_x,
    input  logic signed [COORD_BITS-1:0]  i_vertex_y,
    input  logic                          i_final_vertex,
    input  logic                          i_queue_full,
    output logic                          o_push,
    output logic [2*(1+4*(COORD_BITS+1))-1:0] o_edges,
    output pip_pkg::t_item_ctl            o_ctl
);

    localparam int unsigned DIFF_W = COORD_BITS + 1;
    localparam int unsigned EDGE_W = 1 + 4 * DIFF_W;

    logic [1:0]                   r_seen;
    logic [1:0]                   n_seen;
    logic signed [COORD_BITS-1:0] r_start_x, r_start_y;
    logic signed [COORD_BITS-1:0] r_prior_x, r_prior_y;
    logic signed [COORD_BITS-1:0] r_query_x, r_query_y;

    logic                         first;
    logic [1:0]                   seen_inc;
    logic signed [COORD_BITS-1:0] eff_qx, eff_qy, eff_sx, eff_sy;
    logic [EDGE_W-1:0]            edge_a, edge_b;

    // edge job: straddle flag, then (ty-ly), (rx-lx), (ry-ly), (tx-lx)
    function automatic logic [EDGE_W-1:0] prep_edge(
        input logic signed [COORD_BITS-1:0] nx,
        input logic signed [COORD_BITS-1:0] ny,
        input logic signed [COORD_BITS-1:0] ox,
        input logic signed [COORD_BITS-1:0] oy,
        input logic signed [COORD_BITS-1:0] tx,
        input logic signed [COORD_BITS-1:0] ty
    );
        logic signed [DIFF_W-1:0] lx, ly, rx, ry;
        logic signed [DIFF_W-1:0] da, db, dc, dd;
        logic                     straddle;
        if (nx > ox) begin
            lx = DIFF_W'(ox);
            ly = DIFF_W'(oy);
            rx = DIFF_W'(nx);
            ry = DIFF_W'(ny);
        end else begin
            lx = DIFF_W'(nx);
            ly = DIFF_W'(ny);
            rx = DIFF_W'(ox);
            ry = DIFF_W'(oy);
        end
        da = DIFF_W'(ty) - ly;
        db = rx - lx;
        dc = ry - ly;
        dd = DIFF_W'(tx) - lx;
        straddle = ((nx < tx) == (tx <= ox));
        return {straddle, da, db, dc, dd};
    endfunction

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    assign first    = (r_seen == 2'd0);
    assign seen_inc = (r_seen == 2'(pip_pkg::MIN_VERTICES)) ? r_seen : r_seen + 2'd1;
    assign n_seen   = i_final_vertex ? 2'd0 : seen_inc;

    // the first vertex supplies the query point and the start vertex itself
    assign eff_qx = first ? i_query_x  : r_query_x;
    assign eff_qy = first ? i_query_y  : r_query_y;
    assign eff_sx = first ? i_vertex_x : r_start_x;
    assign eff_sy = first ? i_vertex_y : r_start_y;

    always_comb begin
        edge_a = prep_edge(i_vertex_x, i_vertex_y, r_prior_x, r_prior_y, eff_qx, eff_qy);
        edge_b = prep_edge(eff_sx, eff_sy, i_vertex_x, i_vertex_y, eff_qx, eff_qy);
        edge_a[EDGE_W-1] = edge_a[EDGE_W-1] && !first;
        edge_b[EDGE_W-1] = edge_b[EDGE_W-1] && i_final_vertex;
    end

    assign o_edges      = {edge_a, edge_b};
    assign o_ctl.last   = i_final_vertex;
    assign o_ctl.enough = (seen_inc >= 2'(pip_pkg::MIN_VERTICES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= 2'd0;
            r_start_x <= '0;
            r_start_y <= '0;
            r_prior_x <= '0;
            r_prior_y <= '0;
            r_query_x <= '0;
            r_query_y <= '0;
        end else if (o_push) begin
            r_seen    <= n_seen;
            r_prior_x <= i_vertex_x;
            r_prior_y <= i_vertex_y;
            if (first) begin
                r_start_x <= i_vertex_x;
                r_start_y <= i_vertex_y;
                r_query_x <= i_query_x;
                r_query_y <= i_query_y;
            end
        end
    end

endmodule

@@ rtl/pip_queue.sv @@
// small register queue between the front end and the product unit
// depends on nothing
`timescale 1ns / 1ps

module pip_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == CNT_W'(0));
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/pip_back.sv @@
// back end: cross products, compare, parity accumulation and result register
// depends on pip_pkg
`timescale 1ns / 1ps

module pip_back #(
    parameter int unsigned COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_pop,
    input  logic [2*(1+4*(COORD_BITS+1))-1:0] i_edges,
    input  pip_pkg::t_item_ctl            i_ctl,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_point_inside,
    output logic                          o_enough_vertices
);

    localparam int unsigned DIFF_W = COORD_BITS + 1;
    localparam int unsigned PROD_W = 2 * DIFF_W;
    localparam int unsigned EDGE_W = 1 + 4 * DIFF_W;

    logic [EDGE_W-1:0]        edge_a, edge_b;
    logic signed [DIFF_W-1:0] a_da, a_db, a_dc, a_dd;
    logic signed [DIFF_W-1:0] b_da, b_db, b_dc, b_dd;

    // product stage
    logic                     r_m_valid;
    pip_pkg::t_item_ctl       r_m_ctl;
    logic                     r_m_en_a, r_m_en_b;
    logic signed [PROD_W-1:0] r_pa_lhs, r_pa_rhs, r_pb_lhs, r_pb_rhs;

    // result stage
    logic                     r_out_valid;
    logic                     r_inside, r_enough;
    logic                     r_parity;

    logic                     out_free, m_move, m_free;
    logic                     toggle, n_parity;

    assign edge_a = i_edges[2*EDGE_W-1:EDGE_W];
    assign edge_b = i_edges[EDGE_W-1:0];

    assign {a_da, a_db, a_dc, a_dd} = edge_a[EDGE_W-2:0];
    assign {b_da, b_db, b_dc, b_dd} = edge_b[EDGE_W-2:0];

    // only a final vertex needs the result register
    assign out_free = !r_out_valid || i_ready;
    assign m_move   = r_m_valid && (!r_m_ctl.last || out_free);
    assign m_free   = !r_m_valid || m_move;
    assign o_pop    = i_valid && m_free;

    assign toggle   = (r_m_en_a && (r_pa_lhs < r_pa_rhs))
                    ^ (r_m_en_b && (r_pb_lhs < r_pb_rhs));
    assign n_parity = r_parity ^ toggle;

    always_ff @(posedge i_clk) begin
        if (m_free) begin
            r_m_ctl  <= i_ctl;
            r_m_en_a <= edge_a[EDGE_W-1];
            r_m_en_b <= edge_b[EDGE_W-1];
            r_pa_lhs <= a_da * a_db;
            r_pa_rhs <= a_dc * a_dd;
            r_pb_lhs <= b_da * b_db;
            r_pb_rhs <= b_dc * b_dd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (m_free) begin
            r_m_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_parity    <= 1'b0;
            r_inside    <= 1'b0;
            r_enough    <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (m_move) begin
                if (r_m_ctl.last) begin
                    r_out_valid <= 1'b1;
                    r_inside    <= n_parity && r_m_ctl.enough;
                    r_enough    <= r_m_ctl.enough;
                    r_parity    <= 1'b0;
                end else begin
                    r_parity    <= n_parity;
                end
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_point_inside    = r_inside;
    assign o_enough_vertices = r_enough;

endmodule

@@ rtl/point_in_polygon_test.sv @@
// channel  dir  tdata (low bit up)                         tlast
// s_axis   in   query_x, query_y, vertex_x, vertex_y       final_vertex
// m_axis   out  point_inside, enough_vertices, zero pad    -
//
// one vertex per cycle is taken while the edge-job queue is not full; after its last
// vertex transfer, the result of a polygon passes through the edge-job queue, the
// product register and the result register
// reset is synchronous, active low; no clearing pass is needed
// a stalled output holds its result; the four-entry queue keeps taking vertices
// until it fills, then s_axis_tready drops
//
// top level of the crossing-number point-in-polygon test
// depends on pip_pkg, pip_front, pip_queue, pip_back
`timescale 1ns / 1ps

module point_in_polygon_test #(
    parameter int unsigned COORD_BITS  = pip_pkg::COORD_BITS_DEF,
    parameter int unsigned QUEUE_DEPTH = pip_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // query_x, query_y, vertex_x, vertex_y, zero pad
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // final_vertex
    input  logic                                    s_axis_tlast,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // point_inside, enough_vertices, zero pad
    output logic [pip_pkg::OUT_DATA_W-1:0]          m_axis_tdata
);

    localparam int unsigned DIFF_W  = COORD_BITS + 1;
    localparam int unsigned EDGES_W = 2 * (1 + 4 * DIFF_W);
    localparam int unsigned ENTRY_W = EDGES_W + pip_pkg::CTL_W;

    logic signed [COORD_BITS-1:0] query_x, query_y, vertex_x, vertex_y;
    logic                         push, pop, q_empty, q_full;
    logic [EDGES_W-1:0]           f_edges, b_edges;
    pip_pkg::t_item_ctl           f_ctl, b_ctl;
    logic [ENTRY_W-1:0]           q_wdata, q_rdata;
    logic                         point_inside, enough_vertices;

    assign query_x  = s_axis_tdata[COORD_BITS-1:0];
    assign query_y  = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign vertex_x = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign vertex_y = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];

    pip_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_query_x      (query_x),
        .i_query_y      (query_y),
        .i_vertex_x     (vertex_x),
        .i_vertex_y     (vertex_y),
        .i_final_vertex (s_axis_tlast),
        .i_queue_full   (q_full),
        .o_push         (push),
        .o_edges        (f_edges),
        .o_ctl          (f_ctl)
    );

    assign q_wdata = {f_ctl, f_edges};

    pip_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .i_pop   (pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign b_edges = q_rdata[EDGES_W-1:0];
    assign b_ctl   = q_rdata[ENTRY_W-1:EDGES_W];

    pip_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (!q_empty),
        .o_pop             (pop),
        .i_edges           (b_edges),
        .i_ctl             (b_ctl),
        .o_valid           (m_axis_tvalid),
        .i_ready           (m_axis_tready),
        .o_point_inside    (point_inside),
        .o_enough_vertices (enough_vertices)
    );

    assign m_axis_tdata = {(pip_pkg::OUT_DATA_W - 2)'(0), enough_vertices, point_inside};

endmodule

@@ rtl/pip_checker.sv @@
// port-level checks on the result channel of point_in_polygon_test
// depends on pip_pkg, point_in_polygon_test_macros.svh and point_in_polygon_test
`timescale 1ns / 1ps
`include "point_in_polygon_test_macros.svh"

module pip_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [pip_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    // a result waiting for transfer keeps its value
    `PIP_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // a point can only be inside a polygon with enough vertices
    `PIP_ASSERT_IMPL(a_inside_needs_enough, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1], "inside reported without enough vertices")

    // pad bits of the result stay zero
    `PIP_ASSERT_IMPL(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[pip_pkg::OUT_DATA_W-1:2] == '0, "nonzero pad bits in result")

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ dv/tb_point_in_polygon_test.sv @@
// self-checking testbench for the crossing-number point-in-polygon block
// a vertex driver and a result monitor share an in-file even-odd predictor
// depends on pip_pkg and point_in_polygon_test
`timescale 1ns / 1ps

module tb_point_in_polygon_test;

    localparam int COORD_W  = pip_pkg::COORD_BITS_DEF;
    localparam int S_DATA_W = ((4*COORD_W+7)/8)*8;
    localparam int RANDOM_ITEMS = 1650;
    localparam int CALM_TAIL    = 200;     // last vertices sent with no idling
    localparam int MODE_NEAR    = 0;
    localparam int MODE_WIDE    = 1;
    localparam int MODE_EDGE    = 2;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct {
        t_coord qx;
        t_coord qy;
        t_coord vx;
        t_coord vy;
        logic   last;
    } t_vertex;

    typedef struct {
        logic in_poly;
        logic enough;
    } t_verdict;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    // query_x, query_y, vertex_x, vertex_y, zero pad
    logic [S_DATA_W-1:0]          s_axis_tdata = '0;
    // final_vertex
    logic                         s_axis_tlast = 1'b0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    // point_inside, enough_vertices, zero pad
    logic [pip_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    t_vertex  pending_vertices[$];
    t_verdict expected_verdicts[$];
    int       error_count = 0;

    // predictor state
    t_coord   start_x = '0, start_y = '0, prior_x = '0, prior_y = '0;
    t_coord   held_qx = '0, held_qy = '0;
    logic     parity = 1'b0;
    int       seen_count = 0;

    point_in_polygon_test u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // edge from old end (ox, oy) to new end (nx, ny); products compared exactly
    function automatic logic crossing_toggles(int nx, int ny, int ox, int oy);
        int lx, ly, rx, ry;
        int tx, ty;
        tx = held_qx;
        ty = held_qy;
        if (nx > ox) begin
            lx = ox; ly = oy; rx = nx; ry = ny;
        end else begin
            lx = nx; ly = ny; rx = ox; ry = oy;
        end
        if ((nx < tx) != (tx <= ox))
            return 1'b0;
        return (longint'(ty - ly) * longint'(rx - lx)) <
               (longint'(ry - ly) * longint'(tx - lx));
    endfunction

    function automatic void polygon_step(t_vertex v);
        t_verdict r;
        if (seen_count == 0) begin
            held_qx = v.qx;
            held_qy = v.qy;
            start_x = v.vx;
            start_y = v.vy;
        end else begin
            parity ^= crossing_toggles(v.vx, v.vy, prior_x, prior_y);
        end
        prior_x = v.vx;
        prior_y = v.vy;
        if (seen_count < pip_pkg::MIN_VERTICES)
            seen_count++;
        if (v.last) begin
            parity ^= crossing_toggles(start_x, start_y, v.vx, v.vy);
            r.enough = (seen_count >= pip_pkg::MIN_VERTICES);
            r.in_poly = parity & r.enough;
            expected_verdicts.push_back(r);
            parity = 1'b0;
            seen_count = 0;
        end
    endfunction

    function automatic void push_vertex(int qx, int qy, int vx, int vy, logic last);
        t_vertex v;
        v.qx = t_coord'(qx);
        v.qy = t_coord'(qy);
        v.vx = t_coord'(vx);
        v.vy = t_coord'(vy);
        v.last = last;
        pending_vertices.push_back(v);
    endfunction

    function automatic int pick_coord(int mode, int base);
        int corner[8] = '{-32768, -32767, -1, 0, 1, 2, 32766, 32767};
        case (mode)
            MODE_NEAR: return base + $urandom_range(24) - 12;
            MODE_WIDE: return $urandom_range(65535) - 32768;
            default:   return ($urandom_range(3) == 0) ? $urandom_range(65535) - 32768
                                                       : corner[$urandom_range(7)];
        endcase
    endfunction

    // driver: vertex transfers with random idle bursts
    int src_gap = 0;
    int src_rate = 20;
    int sent_count = 0;

    always @(posedge i_clk) begin
        t_vertex v;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                sent_count++;
                if (sent_count % 50 == 0)
                    src_rate = ($urandom_range(2) == 0) ? 0 : 15 + 25 * $urandom_range(1);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_vertices.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (pending_vertices.size() > CALM_TAIL &&
                             $urandom_range(99) < src_rate) begin
                    src_gap = $urandom_range(3);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    v = pending_vertices.pop_front();
                    polygon_step(v);
                    s_axis_tdata  <= S_DATA_W'({v.vy, v.vx, v.qy, v.qx});
                    s_axis_tlast  <= v.last;
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // monitor: result transfers checked against the oldest expected verdict
    int sink_gap = 0;
    int sink_rate = 20;
    int result_count = 0;

    always @(posedge i_clk) begin
        t_verdict e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                result_count++;
                if (result_count % 8 == 0)
                    sink_rate = ($urandom_range(2) == 0) ? 0 : 15 + 25 * $urandom_range(1);
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected result transfer, tdata %h", m_axis_tdata);
                    error_count++;
                end else begin
                    e = expected_verdicts.pop_front();
                    if (m_axis_tdata[0] !== e.in_poly) begin
                        $error("point_inside: expected %0b, actual %0b",
                               e.in_poly, m_axis_tdata[0]);
                        error_count++;
                    end
                    if (m_axis_tdata[1] !== e.enough) begin
                        $error("enough_vertices: expected %0b, actual %0b",
                               e.enough, m_axis_tdata[1]);
                        error_count++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else if (pending_vertices.size() > CALM_TAIL &&
                         $urandom_range(99) < sink_rate) begin
                sink_gap = $urandom_range(3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int pushed, n, mode, base;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single vertex, then two vertices: both too few
        push_vertex(0, 0, 5, 5, 1'b1);
        push_vertex(3, 3, 0, 0, 1'b0);
        push_vertex(-1, 7, 10, 10, 1'b1);
        // square with the point inside, then outside
        push_vertex(0, 0, -10, -10, 1'b0);
        push_vertex(-32768, 32767, 10, -10, 1'b0);
        push_vertex(32767, -32768, 10, 10, 1'b0);
        push_vertex(-1, -1, -10, 10, 1'b1);
        push_vertex(20, 0, -10, -10, 1'b0);
        push_vertex(0, 0, 10, -10, 1'b0);
        push_vertex(0, 0, 10, 10, 1'b0);
        push_vertex(0, 0, -10, 10, 1'b1);
        // triangle spanning the full coordinate range
        push_vertex(0, 0, -32768, -32768, 1'b0);
        push_vertex(0, 0, 32767, -32768, 1'b0);
        push_vertex(0, 0, 0, 32767, 1'b1);
        // same triangle with the query at the top corner of the range, (32767, 32767)
        push_vertex(32767, 32767, -32768, -32768, 1'b0);
        push_vertex(-32768, -32768, 32767, -32768, 1'b0);
        push_vertex(0, 0, 0, 32767, 1'b1);
        // query sitting on a vertex
        push_vertex(0, 0, 0, 0, 1'b0);
        push_vertex(5, 5, 10, 0, 1'b0);
        push_vertex(5, 5, 0, 10, 1'b1);

        // hold the sender until every result of the directed part is back
        while (pending_vertices.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0)
            @(posedge i_clk);

        pushed = 0;
        while (pushed < RANDOM_ITEMS) begin
            case ($urandom_range(19))
                0:       n = 1 + $urandom_range(1);
                1:       n = 11 + $urandom_range(9);
                default: n = 3 + $urandom_range(7);
            endcase
            case ($urandom_range(9))
                0, 1:    mode = MODE_WIDE;
                2:       mode = MODE_EDGE;
                default: mode = MODE_NEAR;
            endcase
            base = $urandom_range(60000) - 30000;
            for (int k = 0; k < n; k++) begin
                // query fields beyond the first vertex are noise
                if (k == 0)
                    push_vertex(pick_coord(mode, base), pick_coord(mode, base),
                                pick_coord(mode, base), pick_coord(mode, base), n == 1);
                else
                    push_vertex(pick_coord(MODE_WIDE, 0), pick_coord(MODE_WIDE, 0),
                                pick_coord(mode, base), pick_coord(mode, base), k == n - 1);
            end
            pushed += n;
        end

        while (pending_vertices.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
